// ===== rtl/assert_macros.svh =====
// Assertion helper macros used by the RTL sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/renh_pkg.sv =====
// Shared types and constants for the ray edge nearest hit block
package renh_pkg;
    localparam int MaxEdges   = 256;
    localparam int SlotW      = 8;
    localparam int CountW     = 9;
    localparam int FracW      = 17;
    localparam logic [FracW-1:0] NoHit = 17'h10000;
    localparam int ParallelLimit = 168;
    localparam logic ReqLoad  = 1'b0;
    localparam logic ReqQuery = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        edge_slot;
        logic              edge_enabled;
        logic signed [31:0] end_a_x;
        logic signed [31:0] end_a_y;
        logic signed [31:0] end_b_x;
        logic signed [31:0] end_b_y;
        logic signed [31:0] ray_x;
        logic signed [31:0] ray_y;
        logic signed [31:0] ray_dx;
        logic signed [31:0] ray_dy;
    } t_req;

    typedef struct packed {
        logic [16:0] hit_fraction;
        logic        hit_found;
    } t_rsp;

    typedef struct packed {
        logic              on;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_edge;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_TEST, S_DIV, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture query and reset best
        logic rd;         // issue table read for current index
        logic mul;        // form products from read edge
        logic test;       // form cross, numerators and test
        logic div_step;   // one quotient bit
        logic div_end;    // fold quotient into best
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic candidate;
    } t_sts;
endpackage

// ===== rtl/renh_datapath.sv =====
// Edge table, cross products, divider and best-hit register
module renh_datapath
    import renh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_wr,
    input  t_req        i_req,
    input  logic [SlotW-1:0] i_idx,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_rsp        o_rsp
);
    t_edge r_table [MaxEdges];
    t_edge r_edge;
    logic signed [31:0] r_px, r_py, r_dx, r_dy;
    logic signed [67:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic               r_on;
    logic [68:0]        r_rem, r_cr;
    logic [15:0]        r_q;
    logic [FracW-1:0]   r_best;
    logic               r_cand;

    logic signed [32:0] ex, ey, rx, ry;
    logic signed [68:0] cr, nt, nu, acr, ant, anu;
    logic [69:0]        sh;
    logic               ok;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_table[i_req.edge_slot] <= '{i_req.edge_enabled, i_req.end_a_x,
                i_req.end_a_y, i_req.end_b_x, i_req.end_b_y};
        end
        if (i_cmd.rd) r_edge <= r_table[i_idx];
    end

    always_comb begin
        ex = 33'(r_edge.bx) - 33'(r_edge.ax);
        ey = 33'(r_edge.by) - 33'(r_edge.ay);
        rx = 33'(r_edge.ax) - 33'(r_px);
        ry = 33'(r_edge.ay) - 33'(r_py);
        cr = 69'(r_p0) - 69'(r_p1);
        nt = 69'(r_p2) - 69'(r_p3);
        nu = 69'(r_p4) - 69'(r_p5);
        acr = cr[68] ? -cr : cr;
        ant = cr[68] ? -nt : nt;
        anu = cr[68] ? -nu : nu;
        ok = r_on && (acr >= 69'(ParallelLimit)) && !ant[68] && !anu[68]
            && (anu <= acr) && (ant < acr);
        sh = {r_rem, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_req.ray_x;
            r_py <= i_req.ray_y;
            r_dx <= i_req.ray_dx;
            r_dy <= i_req.ray_dy;
            r_best <= NoHit;
        end
        // products: each a 33x33 signed multiply
        if (i_cmd.mul) begin
            r_on <= r_edge.on;
            r_p0 <= 68'(66'(33'(r_dx) * ey));
            r_p1 <= 68'(66'(33'(r_dy) * ex));
            r_p2 <= 68'(66'(rx * ey));
            r_p3 <= 68'(66'(ry * ex));
            r_p4 <= 68'(66'(rx * 33'(r_dy)));
            r_p5 <= 68'(66'(ry * 33'(r_dx)));
        end
        if (i_cmd.test) begin
            r_cand <= ok;
            r_cr   <= acr;
            r_rem  <= ant;
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            if (sh >= {1'b0, r_cr}) begin
                r_rem <= 69'(sh - {1'b0, r_cr});
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= sh[68:0];
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
        if (i_cmd.div_end && r_cand && ({1'b0, r_q} < r_best)) r_best <= {1'b0, r_q};
    end

    assign o_sts.candidate   = r_cand;
    assign o_rsp.hit_fraction = r_best;
    assign o_rsp.hit_found    = (r_best != NoHit);
endmodule

// ===== rtl/renh_ctrl.sv =====
// Sequencer: issues table writes for loads; for queries walks edges, runs the divider
module renh_ctrl
    import renh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_type,
    input  logic [CountW-1:0] i_count,
    input  t_sts              i_sts,
    output logic              o_busy,
    output logic              o_wr,
    output logic              o_done,
    output logic [SlotW-1:0]  o_idx,
    output t_cmd              o_cmd
);
`include "assert_macros.svh"
    t_state r_state, n_state;
    logic [CountW-1:0] r_idx, n_idx, r_lim, n_lim;
    logic [4:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_lim <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_lim <= n_lim;
            r_k <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_lim = r_lim;
        n_k = r_k;
        o_cmd = '0;
        o_wr = 1'b0;
        o_done = 1'b0;
        o_busy = (r_state != S_IDLE);
        o_idx = r_idx[SlotW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_type == ReqLoad) o_wr = 1'b1;
                if (i_start && i_type == ReqQuery) begin
                    o_cmd.load = 1'b1;
                    n_idx = '0;
                    n_lim = (i_count > CountW'(MaxEdges)) ? CountW'(MaxEdges) : i_count;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_idx >= r_lim) n_state = S_DONE;
                else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_k = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // skip the divide for edges that cannot hit
                if (!i_sts.candidate || r_k == 5'd16) begin
                    o_cmd.div_end = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_k = r_k + 1'b1;
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEVER(a_wr_busy, i_clk, i_rst_n, o_wr && o_busy, "table write while busy")
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, o_done |=> !o_busy, "busy after result")
    `ASSERT_NEVER(a_idx_lim, i_clk, i_rst_n, r_idx > r_lim, "index past limit")
    `ASSERT_NEVER(a_k_range, i_clk, i_rst_n, r_k > 5'd16, "divider overrun")
endmodule

// ===== rtl/ray_edge_nearest_hit_top.sv =====
// Top level: nearest ray-edge hit over a loaded edge table
// Usage:
//   Input beats are taken on start when busy is low. A load beat
//   (req_type 0) writes one table slot in that cycle and leaves busy low,
//   so loads run at one per cycle and give no result.
//   A query beat (req_type 1) searches slots 0..min(edge_count, 256)-1 and gives
//   one result beat on o_rsp, marked by o_done for exactly one cycle.
//   Per edge the sequencer steps through S_READ, S_MUL, S_TEST and S_DIV;
//   edges that pass the hit test also run the shared restoring divider,
//   producing one quotient bit per cycle; the table has one read port.
//   Configuration: edge_count is written on i_cfg_valid && o_cfg_ready,
//   ready only while idle. Reset clears edge_count and the sequencer;
//   the table holds garbage until loaded. The receiver cannot stall.
module ray_edge_nearest_hit_top
    import renh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_done,
    output t_rsp              o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CountW-1:0] i_cfg_data
);
    logic [CountW-1:0] r_count;
    logic wr;
    logic [SlotW-1:0] idx;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (i_cfg_valid && o_cfg_ready) r_count <= i_cfg_data;
    end

    renh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_type(i_req.req_type),
        .i_count(r_count), .i_sts(sts), .o_busy(busy), .o_wr(wr), .o_done(o_done),
        .o_idx(idx), .o_cmd(cmd)
    );

    renh_datapath u_dp (
        .i_clk(i_clk), .i_wr(wr), .i_req(i_req), .i_idx(idx), .i_cmd(cmd),
        .o_sts(sts), .o_rsp(o_rsp)
    );
endmodule

// ===== bench/tb_ray_edge_nearest_hit_top.sv =====
// Testbench for the ray edge nearest hit block: directed table, then random loads and queries
`timescale 1ns / 1ps

module tb_ray_edge_nearest_hit_top;
    import renh_pkg::*;

    localparam int StallLimit = 30000;
    localparam logic [31:0] One = 32'd4096;

    typedef struct {
        int   count_before;   // -1 keeps the current edge_count
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              o_done;
    t_rsp              o_rsp;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CountW-1:0] i_cfg_data;

    t_edge       wall_shadow [MaxEdges];
    logic [8:0]  count_shadow;
    t_rsp        hit_q [$];
    int          fail_cnt;
    int          idle_cycles;
    t_row        rows [$];

    ray_edge_nearest_hit_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    function automatic logic signed [127:0] widen(input logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    // exact fixed point search over the shadow table
    function automatic t_rsp nearest_hit(input t_req r);
        logic signed [127:0] px, py, dx, dy, ax, ay, ex, ey, rx, ry;
        logic signed [127:0] cr, nt, nu, q, best;
        int lim;
        t_rsp res;
        px = widen(r.ray_x);
        py = widen(r.ray_y);
        dx = widen(r.ray_dx);
        dy = widen(r.ray_dy);
        best = NoHit;
        lim = (count_shadow > MaxEdges) ? MaxEdges : count_shadow;
        for (int i = 0; i < lim; i++) begin
            if (!wall_shadow[i].on) continue;
            ax = widen(wall_shadow[i].ax);
            ay = widen(wall_shadow[i].ay);
            ex = widen(wall_shadow[i].bx) - ax;
            ey = widen(wall_shadow[i].by) - ay;
            rx = ax - px;
            ry = ay - py;
            cr = dx * ey - dy * ex;
            nt = rx * ey - ry * ex;
            nu = rx * dy - ry * dx;
            if (cr < 0) begin
                cr = -cr;
                nt = -nt;
                nu = -nu;
            end
            if (cr < ParallelLimit) continue;
            if (nt < 0 || nu < 0 || nu > cr || nt >= cr) continue;
            q = (nt <<< 16) / cr;
            if (q < best) best = q;
        end
        res.hit_fraction = best[16:0];
        res.hit_found = (best < NoHit);
        return res;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 65535) - 32'd32768;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.req_type     = 1'($urandom_range(0, 1));
        r.edge_slot    = 8'($urandom);
        r.edge_enabled = 1'($urandom_range(0, 1));
        r.end_a_x      = rand_coord();
        r.end_a_y      = rand_coord();
        r.end_b_x      = rand_coord();
        r.end_b_y      = rand_coord();
        r.ray_x        = rand_coord();
        r.ray_y        = rand_coord();
        r.ray_dx       = rand_coord();
        r.ray_dy       = rand_coord();
        return r;
    endfunction

    function automatic t_req load_req(input logic [7:0] slot, input logic on,
                                      input logic [31:0] ax, ay, bx, by);
        t_req r;
        r = rand_req();
        r.req_type     = ReqLoad;
        r.edge_slot    = slot;
        r.edge_enabled = on;
        r.end_a_x      = ax;
        r.end_a_y      = ay;
        r.end_b_x      = bx;
        r.end_b_y      = by;
        return r;
    endfunction

    function automatic t_req query_req(input logic [31:0] x, y, dx, dy);
        t_req r;
        r = rand_req();
        r.req_type = ReqQuery;
        r.ray_x    = x;
        r.ray_y    = y;
        r.ray_dx   = dx;
        r.ray_dy   = dy;
        return r;
    endfunction

    function automatic t_row mk_row(input int cnt, input t_req r, input bit typed,
                                    input logic [16:0] frac);
        t_row w;
        w.count_before     = cnt;
        w.req              = r;
        w.typed            = typed;
        w.rsp.hit_fraction = frac;
        w.rsp.hit_found    = (frac != NoHit);
        return w;
    endfunction

    // append one row to the directed table
    task automatic add_row(input int cnt, input t_req r, input bit typed,
                           input logic [16:0] frac);
        rows.insert(rows.size(), mk_row(cnt, r, typed, frac));
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input t_req r, input t_rsp typed_rsp, input bit typed);
        int gap;
        case ($urandom_range(0, 19))
            0:              gap = $urandom_range(10, 60);
            1, 2, 3, 4, 5:  gap = $urandom_range(1, 3);
            default:        gap = 0;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        if (r.req_type == ReqLoad) begin
            wall_shadow[r.edge_slot] = '{r.edge_enabled, r.end_a_x, r.end_a_y,
                                         r.end_b_x, r.end_b_y};
        end else begin
            hit_q.insert(hit_q.size(), typed ? typed_rsp : nearest_hit(r));
        end
        @(negedge i_clk);
    endtask

    // drain outstanding results, then write edge_count while idle
    task automatic set_count(input logic [8:0] cnt);
        start <= 1'b0;
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_shadow = cnt;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (hit_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = hit_q.pop_front();
                if (o_rsp.hit_fraction !== want.hit_fraction)
                    report_mismatch($sformatf("hit_fraction %0h, want %0h",
                                              o_rsp.hit_fraction, want.hit_fraction));
                if (o_rsp.hit_found !== want.hit_found)
                    report_mismatch($sformatf("hit_found %0b, want %0b",
                                              o_rsp.hit_found, want.hit_found));
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("tb_ray_edge_nearest_hit_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_items;
        int lim;
        logic [8:0] phase_counts [10];
        t_req r;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        fail_cnt     = 0;
        idle_cycles  = 0;
        count_shadow = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty search, then a small table with a hit, a parallel, a disabled and a
        // one-lsb edge, then end of ray, edge endpoint, origin on edge, backward ray
        add_row(0, query_req(0, 0, 2 * One, 0), 1, NoHit);
        add_row(-1, load_req(0, 1, One, -4 * One, One, 4 * One), 0, 0);
        add_row(-1, load_req(1, 1, 0, One, 8 * One, One), 0, 0);
        add_row(-1, load_req(2, 0, One / 2, -4 * One, One / 2, 4 * One), 0, 0);
        add_row(-1, load_req(3, 1, 3 * One, 0, 3 * One, 1), 0, 0);
        add_row(-1, load_req(255, 1, 32'h8000_0000, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h8000_0000), 0, 0);
        add_row(4, query_req(0, 0, 2 * One, 0), 1, 17'h08000);
        add_row(-1, query_req(0, 0, One, 0), 1, NoHit);
        add_row(-1, query_req(0, 4 * One, 2 * One, 0), 1, 17'h08000);
        add_row(-1, query_req(One, 0, One, 0), 1, 17'h00000);
        add_row(-1, query_req(0, 0, -2 * One, 0), 1, NoHit);
        add_row(-1, query_req(3 * One - 100, 0, 167, 0), 0, 0);
        add_row(-1, query_req(3 * One - 100, 0, 168, 0), 0, 0);
        add_row(-1, query_req(32'h8000_0000, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h8000_0000), 0, 0);
        add_row(-1, query_req($urandom, $urandom, $urandom, $urandom), 0, 0);
        foreach (rows[i]) begin
            if (rows[i].count_before >= 0) set_count(9'(rows[i].count_before));
            send_beat(rows[i].req, rows[i].rsp, rows[i].typed);
        end

        // fill every slot so any count is legal from here on
        for (int s = 0; s < MaxEdges; s++) begin
            send_beat(load_req(8'(s), $urandom_range(0, 6) != 0, rand_coord(), rand_coord(),
                               rand_coord(), rand_coord()), '0, 0);
        end

        phase_counts = '{9'd1, 9'd3, 9'd8, 9'd2, 9'd16, 9'd256, 9'd511, 9'd5, 9'd0, 9'd40};
        foreach (phase_counts[p]) begin
            set_count(phase_counts[p]);
            lim = (phase_counts[p] > 16) ? 8 : 62;
            n_items = 0;
            while (n_items < lim) begin
                r = rand_req();
                // keep big searches mostly queries, small ones mixed
                if (lim == 8) r.req_type = ($urandom_range(0, 3) != 0) ? ReqQuery : ReqLoad;
                else r.req_type = ($urandom_range(0, 9) < 6) ? ReqQuery : ReqLoad;
                send_beat(r, '0, 0);
                n_items++;
            end
        end

        start <= 1'b0;
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_ray_edge_nearest_hit_top OK");
        end else begin
            $display("tb_ray_edge_nearest_hit_top NOT OK");
        end
        $finish;
    end

endmodule
